### sv/adaptive_window_throughput_meter_defines.svh
// Assertion macros shared by the throughput meter RTL.
`ifndef ADAPTIVE_WINDOW_THROUGHPUT_METER_DEFINES_SVH
`define ADAPTIVE_WINDOW_THROUGHPUT_METER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AWTM_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AWTM_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/awtm_pkg.sv
// Types, constants and helper functions of the throughput meter.
package awtm_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int BYTE_W       = 48;
  localparam int TIME_W       = 63;
  localparam int RES_W        = 31;
  localparam int TPS_W        = 8;
  localparam int PCT_W        = 16;
  localparam int ETA_W        = 33;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int USEC_W       = 20;
  localparam int PROD_W       = BYTE_W + TIME_W;
  localparam int DEN_W        = BYTE_W + USEC_W;
  localparam int RATIO_W      = BYTE_W + 7;
  localparam int DIV_CNT_W    = 7;
  localparam int MUL_CNT_W    = 6;
  localparam int ENTRY_W      = TIME_W + BYTE_W;

  localparam logic [USEC_W-1:0] USEC      = 20'd1000000;
  localparam logic [6:0]        PCT_SCALE = 7'd100;

  localparam logic KIND_PROGRESS = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_TOTAL = 3'd0,
    CFG_TICKS_PER_SLOT = 3'd1,
    CFG_MAX_GROW       = 3'd2,
    CFG_MIN_SHRINK     = 3'd3,
    CFG_ETA_HOLD       = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ETA_CHK,
    ST_MUL,
    ST_ETA_DIV,
    ST_TICK,
    ST_BND_RD1,
    ST_BND_RD2,
    ST_BND_DIV,
    ST_BND_WR,
    ST_SPD_RD,
    ST_SPD_CHK,
    ST_SPD_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] byte_count;
    logic [TIME_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic             speed_valid;
    logic [RES_W-1:0] speed_bps;
    logic             eta_valid;
    logic [RES_W-1:0] eta_seconds;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
    logic [PROD_W-1:0]    num;
    logic [DEN_W-1:0]     den;
  } div_req_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] idx);
    return (idx == SLOT_W'(SLOT_COUNT - 1)) ? '0 : idx + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] idx);
    return (idx == '0) ? SLOT_W'(SLOT_COUNT - 1) : idx - SLOT_W'(1);
  endfunction

  function automatic logic [RES_W-1:0] sat_res(input logic [PROD_W-1:0] q);
    return (|q[PROD_W-1:RES_W]) ? '1 : q[RES_W-1:0];
  endfunction

endpackage

### sv/adaptive_window_throughput_meter.sv
// Throughput meter top level: slot ring in RAM, sequencer, multiplier, output register.
//
//   channel  | direction | handshake               | payload
//   in       | input     | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
//   out      | output    | out_valid_o / out_stall_i| out_data_o (out_item_t)
//   cfg      | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// A progress item is taken in the idle state. The work of a report item is set by
// the bit-serial 48-bit multiplier and the shared one-bit-per-cycle divider
// (111, 55 and 68 steps for ETA, slot ratio and speed), plus slot RAM reads.
// Reset clears all control state; no clearing pass is needed since slots carry
// in-use flags. A stalled result waits in the output register; the next item is
// accepted meanwhile and waits at the end of its work if the register is still full.
`include "adaptive_window_throughput_meter_defines.svh"
module adaptive_window_throughput_meter import awtm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [BYTE_W-1:0]     exp_tot_q, exp_tot_d;
  logic [TPS_W-1:0]      tps_q, tps_d;
  logic [PCT_W-1:0]      grow_q, grow_d;
  logic [PCT_W-1:0]      shrink_q, shrink_d;
  logic [PCT_W-1:0]      hold_q, hold_d;

  logic [BYTE_W-1:0]     bytes_now_q, bytes_now_d;
  logic                  started_q, started_d;
  logic [SLOT_W-1:0]     newest_q, newest_d;
  logic [SLOT_W-1:0]     window_q, window_d;
  logic [TPS_W-1:0]      ticks_q, ticks_d;
  logic [ETA_W-1:0]      last_eta_q, last_eta_d;
  logic [SLOT_COUNT-1:0] used_q, used_d;

  logic [TIME_W-1:0]     now_q, now_d;
  logic [BYTE_W-1:0]     mul_a_q, mul_a_d;
  logic [TIME_W-1:0]     mul_b_q, mul_b_d;
  logic [PROD_W-1:0]     mul_acc_q, mul_acc_d;
  logic [MUL_CNT_W-1:0]  mul_cnt_q, mul_cnt_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic [BYTE_W-1:0]     bn_q, bn_d;
  logic                  eta_ok_q, eta_ok_d;
  logic [RES_W-1:0]      eta_val_q, eta_val_d;
  logic                  spd_ok_q, spd_ok_d;
  logic [RES_W-1:0]      spd_val_q, spd_val_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_data_q, out_data_d;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]     rd_start;
  logic [BYTE_W-1:0]     rd_bytes;

  div_req_t              div_req;
  logic                  div_busy;
  logic                  div_done;
  logic [PROD_W-1:0]     div_quot;

  logic                  in_acc;
  logic                  tick_go;
  logic [SLOT_W-1:0]     eta_slot;
  logic [SLOT_W-1:0]     old_slot;
  logic [SLOT_W-1:0]     nn_slot;
  logic [BYTE_W-1:0]     delta_rd;
  logic [DEN_W-1:0]      delta_usec;
  logic                  time_ok;
  logic                  eta_go;
  logic                  spd_go;
  logic                  out_free;
  logic                  tick_bnd;
  logic                  ratio_restart;
  logic [RES_W-1:0]      raw;
  logic signed [ETA_W:0] raw_s, last_s, upper_s;
  logic                  held;
  logic [BYTE_W-1:0]     cur, prev;
  logic [RATIO_W-1:0]    ratio_num;

  awtm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  awtm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_go    = in_acc && in_data_i.kind == KIND_TICK && bytes_now_q != '0;
  assign rd_start   = ram_rdata[ENTRY_W-1:BYTE_W];
  assign rd_bytes   = ram_rdata[BYTE_W-1:0];
  assign eta_slot   = slot_next(newest_q);
  assign old_slot   = slot_prev(newest_q);
  assign nn_slot    = slot_next(newest_q);
  assign delta_rd   = (bytes_now_q > rd_bytes) ? bytes_now_q - rd_bytes : '0;
  assign delta_usec = DEN_W'(delta_rd) * DEN_W'(USEC);
  assign time_ok    = now_q > rd_start;
  assign eta_go     = used_q[eta_slot] && (exp_tot_q > bytes_now_q) && time_ok &&
                      (delta_rd != '0);
  assign spd_go     = used_q[window_q] && time_ok;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tick_bnd   = ticks_q <= TPS_W'(1);

  assign cur       = (bytes_now_q > bn_q) ? bytes_now_q - bn_q : '0;
  assign prev      = (bn_q > rd_bytes) ? bn_q - rd_bytes : '0;
  assign ratio_num = RATIO_W'(cur) * RATIO_W'(PCT_SCALE);
  assign ratio_restart = (div_quot >= PROD_W'(grow_q)) || (div_quot <= PROD_W'(shrink_q));

  // ETA hold window: a rise smaller than the hold time keeps the last value.
  assign raw     = sat_res(div_quot);
  assign raw_s   = $signed({3'b000, raw});
  assign last_s  = $signed({last_eta_q[ETA_W-1], last_eta_q});
  assign upper_s = last_s + $signed({{(ETA_W + 1 - PCT_W){1'b0}}, hold_q});
  assign held    = (raw_s >= last_s) && (raw_s < upper_s);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_go) begin
          state_d = ST_ETA_CHK;
        end
      end
      ST_ETA_CHK: state_d = eta_go ? ST_MUL : ST_TICK;
      ST_MUL: begin
        if (mul_cnt_q == '0) begin
          state_d = ST_ETA_DIV;
        end
      end
      ST_ETA_DIV: begin
        if (div_done) begin
          state_d = ST_TICK;
        end
      end
      ST_TICK:    state_d = tick_bnd ? ST_BND_RD1 : ST_SPD_RD;
      ST_BND_RD1: state_d = used_q[old_slot] ? ST_BND_RD2 : ST_BND_WR;
      ST_BND_RD2: state_d = ST_BND_DIV;
      ST_BND_DIV: begin
        if (div_done) begin
          state_d = ST_BND_WR;
        end
      end
      ST_BND_WR:  state_d = ST_SPD_RD;
      ST_SPD_RD:  state_d = ST_SPD_CHK;
      ST_SPD_CHK: state_d = spd_go ? ST_SPD_DIV : ST_OUT;
      ST_SPD_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    exp_tot_d   = exp_tot_q;
    tps_d       = tps_q;
    grow_d      = grow_q;
    shrink_d    = shrink_q;
    hold_d      = hold_q;
    bytes_now_d = bytes_now_q;
    started_d   = started_q;
    newest_d    = newest_q;
    window_d    = window_q;
    ticks_d     = ticks_q;
    last_eta_d  = last_eta_q;
    used_d      = used_q;
    now_d       = now_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_acc_d   = mul_acc_q;
    mul_cnt_d   = mul_cnt_q;
    den_d       = den_q;
    bn_d        = bn_q;
    eta_ok_d    = eta_ok_q;
    eta_val_d   = eta_val_q;
    spd_ok_d    = spd_ok_q;
    spd_val_d   = spd_val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {now_q, bytes_now_q};
    ram_raddr   = eta_slot;
    div_req     = '{start: 1'b0, iters: '0, num: '0, den: '0};

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EXPECTED_TOTAL: exp_tot_d = cfg_data_i[BYTE_W-1:0];
        CFG_TICKS_PER_SLOT: tps_d     = cfg_data_i[TPS_W-1:0];
        CFG_MAX_GROW:       grow_d    = cfg_data_i[PCT_W-1:0];
        CFG_MIN_SHRINK:     shrink_d  = cfg_data_i[PCT_W-1:0];
        CFG_ETA_HOLD:       hold_d    = cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind == KIND_PROGRESS) begin
            bytes_now_d = in_data_i.byte_count;
            if (!started_q) begin
              // The first progress item opens slot 0.
              started_d = 1'b1;
              used_d[0] = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_data_i.time_us, {BYTE_W{1'b0}}};
            end
          end else begin
            now_d     = in_data_i.time_us;
            eta_ok_d  = 1'b0;
            eta_val_d = '0;
            spd_ok_d  = 1'b0;
            spd_val_d = '0;
          end
        end
      end
      ST_ETA_CHK: begin
        if (eta_go) begin
          mul_a_d   = exp_tot_q - bytes_now_q;
          mul_b_d   = now_q - rd_start;
          mul_acc_d = '0;
          mul_cnt_d = MUL_CNT_W'(BYTE_W);
          den_d     = delta_usec;
        end
      end
      ST_MUL: begin
        if (mul_cnt_q != '0) begin
          mul_acc_d = {mul_acc_q[PROD_W-2:0], 1'b0} +
                      (mul_a_q[BYTE_W-1] ? PROD_W'(mul_b_q) : '0);
          mul_a_d   = {mul_a_q[BYTE_W-2:0], 1'b0};
          mul_cnt_d = mul_cnt_q - MUL_CNT_W'(1);
        end else begin
          // Dividing once by delta * 1e6 equals the two truncating divisions.
          div_req = '{start: 1'b1, iters: DIV_CNT_W'(PROD_W), num: mul_acc_q, den: den_q};
        end
      end
      ST_ETA_DIV: begin
        if (div_done) begin
          if (held) begin
            if (!last_eta_q[ETA_W-1]) begin
              eta_ok_d  = 1'b1;
              eta_val_d = last_eta_q[RES_W-1:0];
            end
          end else begin
            last_eta_d = ETA_W'(raw);
            eta_ok_d   = 1'b1;
            eta_val_d  = raw;
          end
        end
      end
      ST_TICK: begin
        if (exp_tot_q <= bytes_now_q) begin
          exp_tot_d = bytes_now_q;
        end
        if (tick_bnd) begin
          ticks_d = (tps_q == '0) ? TPS_W'(1) : tps_q;
        end else begin
          ticks_d = ticks_q - TPS_W'(1);
        end
        ram_raddr = newest_q;
      end
      ST_BND_RD1: begin
        bn_d      = rd_bytes;
        ram_raddr = old_slot;
      end
      ST_BND_RD2: begin
        div_req = '{start: 1'b1,
                    iters: DIV_CNT_W'(RATIO_W),
                    num:   {ratio_num, {(PROD_W - RATIO_W){1'b0}}},
                    den:   DEN_W'(prev) + DEN_W'(1)};
      end
      ST_BND_DIV: begin
        if (div_done && ratio_restart) begin
          window_d = newest_q;
        end
      end
      ST_BND_WR: begin
        newest_d        = nn_slot;
        used_d[nn_slot] = 1'b1;
        ram_we          = 1'b1;
        ram_waddr       = nn_slot;
        ram_wdata       = {now_q, bytes_now_q};
        if (nn_slot == window_q) begin
          window_d = slot_next(window_q);
        end
      end
      ST_SPD_RD: begin
        ram_raddr = window_q;
      end
      ST_SPD_CHK: begin
        if (spd_go) begin
          div_req = '{start: 1'b1,
                      iters: DIV_CNT_W'(DEN_W),
                      num:   {delta_usec, {(PROD_W - DEN_W){1'b0}}},
                      den:   DEN_W'(now_q - rd_start)};
        end
      end
      ST_SPD_DIV: begin
        if (div_done) begin
          spd_ok_d  = 1'b1;
          spd_val_d = raw;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{speed_valid: spd_ok_q, speed_bps: spd_val_q,
                          eta_valid: eta_ok_q, eta_seconds: eta_val_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_tot_q   <= '0;
      tps_q       <= TPS_W'(4);
      grow_q      <= PCT_W'(200);
      shrink_q    <= PCT_W'(50);
      hold_q      <= PCT_W'(10);
      bytes_now_q <= '0;
      started_q   <= 1'b0;
      newest_q    <= '0;
      window_q    <= '0;
      ticks_q     <= TPS_W'(4);
      last_eta_q  <= -ETA_W'(10);
      used_q      <= '0;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_tot_q   <= exp_tot_d;
      tps_q       <= tps_d;
      grow_q      <= grow_d;
      shrink_q    <= shrink_d;
      hold_q      <= hold_d;
      bytes_now_q <= bytes_now_d;
      started_q   <= started_d;
      newest_q    <= newest_d;
      window_q    <= window_d;
      ticks_q     <= ticks_d;
      last_eta_q  <= last_eta_d;
      used_q      <= used_d;
      mul_cnt_q   <= mul_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    mul_acc_q  <= mul_acc_d;
    den_q      <= den_d;
    bn_q       <= bn_d;
    eta_ok_q   <= eta_ok_d;
    eta_val_q  <= eta_val_d;
    spd_ok_q   <= spd_ok_d;
    spd_val_q  <= spd_val_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `AWTM_IMPL(a_newest_used, started_q, used_q[newest_q], "newest slot is not in use")
  `AWTM_IMPL(a_div_start_idle, div_req.start, !div_busy, "divider restarted while busy")
  `AWTM_NEXT(a_tick_runs, tick_go, state_q == ST_ETA_CHK, "report item not started")

endmodule

### sv/awtm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module awtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/awtm_div.sv
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
module awtm_div import awtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [PROD_W-1:0] quot_o
);

  logic [PROD_W-1:0]    dq_q, dq_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign shifted = {rem_q, dq_q[PROD_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dq_d  = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
      cnt_d = req_i.iters;
    end else if (cnt_q != '0) begin
      // The remainder stays below the divisor, so it fits without its top bit.
      rem_d  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dq_d   = {dq_q[PROD_W-2:0], ge};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the adaptive window throughput meter.
module tb_top;
  import awtm_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD     = 4000;
  localparam int N_PHASES      = 6;
  localparam int PHASE_ITEMS   = 67;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [127:0] SAT_Q = 128'h7FFF_FFFF;
  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] bytes;
    logic [TIME_W-1:0] t_us;
    bit                typed;
    out_item_t         want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  adaptive_window_throughput_meter u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted meter state and register copies.
  logic [TIME_W-1:0] m_slot_start [SLOT_COUNT];
  logic [BYTE_W-1:0] m_slot_bytes [SLOT_COUNT];
  bit                m_slot_used  [SLOT_COUNT];
  logic [BYTE_W-1:0] m_bytes_now;
  bit                m_started;
  int                m_newest, m_window, m_ticks_left;
  longint            m_last_eta;
  logic [BYTE_W-1:0] r_total;
  logic [7:0]        r_tps;
  logic [15:0]       r_grow, r_shrink, r_hold;

  out_item_t pending_reports[$];
  int n_errors = 0;
  int n_reports = 0;
  int n_items = 0;
  int n_etas = 0;
  int n_speeds = 0;
  int cycles = 0;
  bit calm_in = 0;
  logic long_hold_q = 1'b0;

  function automatic logic [BYTE_W-1:0] sub_floor(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      m_slot_start[i] = '0;
      m_slot_bytes[i] = '0;
      m_slot_used[i] = 0;
    end
    m_bytes_now = '0;
    m_started = 0;
    m_newest = 0;
    m_window = 0;
    m_ticks_left = 4;
    m_last_eta = -10;
    r_total = '0;
    r_tps = 8'd4;
    r_grow = 16'd200;
    r_shrink = 16'd50;
    r_hold = 16'd10;
  endtask

  task automatic advance_slot(logic [TIME_W-1:0] now);
    int old;
    logic [63:0] cur, prev, change;
    old = (m_newest + SLOT_COUNT - 1) % SLOT_COUNT;
    if (m_slot_used[old]) begin
      cur = 64'(sub_floor(m_bytes_now, m_slot_bytes[m_newest]));
      prev = 64'(sub_floor(m_slot_bytes[m_newest], m_slot_bytes[old]));
      change = (64'd100 * cur) / (prev + 64'd1);
      if (change >= 64'(r_grow) || change <= 64'(r_shrink)) m_window = m_newest;
    end
    m_newest = (m_newest + 1) % SLOT_COUNT;
    m_slot_bytes[m_newest] = m_bytes_now;
    m_slot_start[m_newest] = now;
    m_slot_used[m_newest] = 1;
    if (m_newest == m_window) m_window = (m_window + 1) % SLOT_COUNT;
  endtask

  // Advances the predicted state by one item; returns 1 when a report is due.
  task automatic predict_report(input in_item_t it, output bit has, output out_item_t res);
    int s;
    logic [BYTE_W-1:0] delta;
    logic [127:0] q;
    longint raw;
    has = 0;
    res = '0;
    if (it.kind == KIND_PROGRESS) begin
      if (!m_started) begin
        m_started = 1;
        m_slot_start[0] = it.time_us;
        m_slot_used[0] = 1;
      end
      m_bytes_now = it.byte_count;
      return;
    end
    if (m_bytes_now == '0) return;
    has = 1;
    s = (m_newest + 1) % SLOT_COUNT;
    if (m_slot_used[s] && r_total > m_bytes_now && it.time_us > m_slot_start[s]) begin
      delta = sub_floor(m_bytes_now, m_slot_bytes[s]);
      if (delta != '0) begin
        q = 128'(r_total - m_bytes_now) * 128'(it.time_us - m_slot_start[s]);
        q = q / 128'(delta) / 128'(USEC);
        raw = (q > SAT_Q) ? longint'(SAT_Q) : longint'(q);
        if (raw >= m_last_eta && raw < m_last_eta + longint'(r_hold)) begin
          if (m_last_eta >= 0) begin
            res.eta_valid = 1'b1;
            res.eta_seconds = RES_W'(m_last_eta);
          end
        end else begin
          m_last_eta = raw;
          res.eta_valid = 1'b1;
          res.eta_seconds = RES_W'(raw);
        end
      end
    end
    if (r_total <= m_bytes_now) r_total = m_bytes_now;
    if (m_ticks_left <= 1) begin
      m_ticks_left = (r_tps == 8'd0) ? 1 : int'(r_tps);
      advance_slot(it.time_us);
    end else begin
      m_ticks_left--;
    end
    s = m_window;
    if (m_slot_used[s] && it.time_us > m_slot_start[s]) begin
      q = 128'(sub_floor(m_bytes_now, m_slot_bytes[s])) * 128'(USEC);
      q = q / 128'(it.time_us - m_slot_start[s]);
      res.speed_valid = 1'b1;
      res.speed_bps = (q > SAT_Q) ? RES_W'(SAT_Q) : RES_W'(q);
    end
  endtask

  // Short gaps mostly, with a rare long one and calm stretches with none.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(39) == 0) calm_in = !calm_in;
    if (calm_in) return 0;
    r = $urandom_range(15);
    if (r < 10) return 0;
    if (r < 15) return $urandom_range(3, 1);
    return $urandom_range(120, 20);
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    bit has;
    out_item_t res;
    int g;
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    predict_report(it, has, res);
    if (typed) res = want;
    if (has || typed) begin
      pending_reports.push_back(res);
      if (res.eta_valid) n_etas++;
      if (res.speed_valid) n_speeds++;
    end
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Register writes go in only while no item is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EXPECTED_TOTAL: r_total = val;
      CFG_TICKS_PER_SLOT: r_tps = val[7:0];
      CFG_MAX_GROW:       r_grow = val[15:0];
      CFG_MIN_SHRINK:     r_shrink = val[15:0];
      CFG_ETA_HOLD:       r_hold = val[15:0];
      default: ;
    endcase
  endtask

  // Random stalls on the result side, plus a long counted hold on request.
  int hold_left = 0;
  int burst_left = 0;
  bit calm_out = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(199) == 0) calm_out = !calm_out;
    if (long_hold_q) hold_left = LONG_HOLD;
    else if (hold_left > 0) hold_left--;
    if (burst_left > 0) burst_left--;
    else if (!calm_out && $urandom_range(63) == 0) burst_left = $urandom_range(80, 20);
    out_stall_i <= (hold_left > 0) || (burst_left > 0) ||
                   (!calm_out && $urandom_range(3) == 0);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_reports++;
      if (pending_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected report %p", out_data_o);
      end else begin
        want = pending_reports.pop_front();
        if (out_data_o.speed_valid !== want.speed_valid ||
            out_data_o.speed_bps !== want.speed_bps ||
            out_data_o.eta_valid !== want.eta_valid ||
            out_data_o.eta_seconds !== want.eta_seconds) begin
          n_errors++;
          if (n_errors <= 10)
            $display("report %0d mismatch: expected %p, got %p", n_reports, want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("adaptive_window_throughput_meter regression: fail");
      $finish;
    end
  end

  function automatic out_item_t rpt(bit sv, int sp, bit ev, int es);
    out_item_t o;
    o.speed_valid = sv;
    o.speed_bps = RES_W'(sp);
    o.eta_valid = ev;
    o.eta_seconds = RES_W'(es);
    return o;
  endfunction

  initial begin
    row_t rows[$];
    in_item_t it;
    logic [BYTE_W-1:0] b_run;
    logic [TIME_W-1:0] t_run;
    int r;

    reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run under the reset register values.
    rows.push_back('{KIND_TICK, 48'd0, 63'd500, 1'b0, '0});        // nothing counted yet
    rows.push_back('{KIND_PROGRESS, 48'd1000, 63'd1000000, 1'b0, '0});
    rows.push_back('{KIND_TICK, 48'd0, 63'd2000000, 1'b1, rpt(1, 1000, 0, 0)});
    rows.push_back('{KIND_TICK, 48'd0, 63'd1000000, 1'b1, rpt(0, 0, 0, 0)});  // zero elapsed
    rows.push_back('{KIND_TICK, 48'd0, 63'd5, 1'b1, rpt(0, 0, 0, 0)});        // time backward
    rows.push_back('{KIND_TICK, 48'd0, 63'd3000000, 1'b1, rpt(1, 500, 0, 0)});
    rows.push_back('{KIND_PROGRESS, 48'd10, 63'd3100000, 1'b0, '0});          // bytes backward
    rows.push_back('{KIND_TICK, BYTE_MAX, 63'd4000000, 1'b0, '0});
    rows.push_back('{KIND_PROGRESS, 48'd500000, 63'd4500000, 1'b0, '0});
    rows.push_back('{KIND_TICK, 48'd0, 63'd5000000, 1'b0, '0});
    rows.push_back('{KIND_PROGRESS, BYTE_MAX, TIME_MAX, 1'b0, '0});
    rows.push_back('{KIND_TICK, 48'd0, 63'd5000001, 1'b0, '0});
    rows.push_back('{KIND_TICK, BYTE_MAX, TIME_MAX, 1'b0, '0});
    rows.push_back('{KIND_PROGRESS, 48'd1, 63'd1, 1'b0, '0});
    rows.push_back('{KIND_TICK, 48'd0, TIME_MAX, 1'b0, '0});
    rows.push_back('{KIND_PROGRESS, 48'd2000000, 63'd7000000, 1'b0, '0});
    for (int i = 0; i < 6; i++)
      rows.push_back('{KIND_TICK, 48'd0, 63'(64'd8000000 + 64'(i) * 1000000), 1'b0, '0});
    foreach (rows[i]) begin
      it.kind = rows[i].kind;
      it.byte_count = rows[i].bytes;
      it.time_us = rows[i].t_us;
      send_item(it, rows[i].typed, rows[i].want);
    end

    b_run = 48'd3000000;
    t_run = 63'd20000000;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (ph)
        0: begin
          write_reg(CFG_EXPECTED_TOTAL, 48'(b_run) + 48'd400000000);
          write_reg(CFG_TICKS_PER_SLOT, 48'd1);
          write_reg(CFG_UNUSED, '1);
        end
        1: begin
          write_reg(CFG_TICKS_PER_SLOT, 48'd0);
          write_reg(CFG_MAX_GROW, 48'd0);
          write_reg(CFG_MIN_SHRINK, 48'd65535);
          write_reg(CFG_ETA_HOLD, 48'd0);
          write_reg(CFG_EXPECTED_TOTAL, 48'(BYTE_MAX));
        end
        2: begin
          write_reg(CFG_TICKS_PER_SLOT, 48'd255);
          write_reg(CFG_MAX_GROW, 48'd65535);
          write_reg(CFG_MIN_SHRINK, 48'd0);
          write_reg(CFG_ETA_HOLD, 48'd65535);
        end
        3: begin
          write_reg(CFG_TICKS_PER_SLOT, 48'd2);
          write_reg(CFG_MAX_GROW, 48'd150);
          write_reg(CFG_MIN_SHRINK, 48'd70);
          write_reg(CFG_ETA_HOLD, 48'd5);
          write_reg(CFG_EXPECTED_TOTAL, 48'd0);
        end
        default: begin
          write_reg(CFG_EXPECTED_TOTAL, 48'(b_run) + 48'($urandom_range(1 << 30)));
          write_reg(CFG_TICKS_PER_SLOT, 48'($urandom_range(8, 1)));
          write_reg(CFG_MAX_GROW, 48'($urandom_range(400, 100)));
          write_reg(CFG_MIN_SHRINK, 48'($urandom_range(90, 10)));
          write_reg(CFG_ETA_HOLD, 48'($urandom_range(30)));
        end
      endcase
      if (ph == 3) begin
        long_hold_q <= 1'b1;
        @(posedge clk_i);
        long_hold_q <= 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) wait_drained();
        r = $urandom_range(99);
        it = '0;
        if (r < 6) begin
          // Noise: arbitrary counts and timestamps over the full field widths.
          it.kind = 1'($urandom_range(1));
          it.byte_count = BYTE_W'({$urandom(), $urandom()});
          it.time_us = TIME_W'({$urandom(), $urandom()});
        end else if (r < 10) begin
          it.kind = KIND_PROGRESS;
          it.byte_count = b_run - 48'($urandom_range(100000));
          it.time_us = t_run - 63'($urandom_range(2000000));
        end else if (r < 55) begin
          b_run += 48'($urandom_range(r < 20 ? 50000000 : 2000000));
          t_run += 63'($urandom_range(500000));
          it.kind = KIND_PROGRESS;
          it.byte_count = b_run;
          it.time_us = t_run;
        end else begin
          t_run += 63'($urandom_range(1500000, 1));
          it.kind = KIND_TICK;
          it.byte_count = BYTE_W'({$urandom(), $urandom()});
          it.time_us = t_run;
        end
        send_item(it, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d items sent, %0d reports checked (%0d with speed, %0d with ETA)",
             n_items, n_reports, n_speeds, n_etas);
    $display("register phases covered tick-per-slot 0, 1, 255 and limit extremes");
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("adaptive_window_throughput_meter regression: pass");
    end else begin
      $display("%0d mismatches, %0d reports missing", n_errors, pending_reports.size());
      $display("adaptive_window_throughput_meter regression: fail");
    end
    $finish;
  end
endmodule

### adaptive_window_throughput_meter.f
+incdir+sv
sv/awtm_pkg.sv
sv/awtm_ram.sv
sv/awtm_div.sv
sv/adaptive_window_throughput_meter.sv
bench/tb_top.sv
